FILE: src/qrs_pkg.sv
package qrs_pkg;

	// Root classes reported on root_class
	typedef enum logic [1:0] {
		CLS_TWO   = 2'd0,
		CLS_ONE   = 2'd1,
		CLS_NONE  = 2'd2,
		CLS_AZERO = 2'd3
	} root_class_t;

	// Fraction bits added to the root (Q16.16 result from Q8.8 inputs)
	localparam int FRAC_SHIFT = 16;

endpackage

FILE: src/qrs_sqrt.sv
// Pipelined restoring square root, one root bit per stage.
// root = floor(sqrt(d * 2^32)); a tag rides along with each transaction.
module qrs_sqrt import qrs_pkg::*; #(
	parameter int NR    = 33,
	parameter int TAG_W = 34
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  logic                  vld_in,
	input  logic [2*NR-33:0]      d_in,
	input  logic [TAG_W-1:0]      tag_in,
	output logic                  vld_out,
	output logic [NR-1:0]         root_out,
	output logic [TAG_W-1:0]      tag_out
);

	localparam int DP  = 2*NR - 32;
	localparam int RMW = NR + 2;

	logic             vld_s  [NR];
	logic [RMW-1:0]   rem_s  [NR];
	logic [NR-1:0]    root_s [NR];
	logic [DP-1:0]    d_s    [NR];
	logic [TAG_W-1:0] tag_s  [NR];

	for (genvar gi = 0; gi < NR; gi++) begin : g_stg
		localparam int P = NR - 1 - gi;
		logic             vld_i;
		logic [RMW-1:0]   rem_i;
		logic [NR-1:0]    root_i;
		logic [DP-1:0]    d_i;
		logic [TAG_W-1:0] tag_i;
		logic [1:0]       pair;
		logic [RMW+1:0]   rem_sh;
		logic [RMW+1:0]   trial;
		logic [RMW+1:0]   diff;
		logic             take;

		if (gi == 0) begin : g_first
			assign vld_i  = vld_in;
			assign rem_i  = '0;
			assign root_i = '0;
			assign d_i    = d_in;
			assign tag_i  = tag_in;
		end else begin : g_next
			assign vld_i  = vld_s[gi-1];
			assign rem_i  = rem_s[gi-1];
			assign root_i = root_s[gi-1];
			assign d_i    = d_s[gi-1];
			assign tag_i  = tag_s[gi-1];
		end

		// low 16 digit pairs come from the 2^32 scale and are zero
		if (P >= 16) begin : g_data
			assign pair = d_i[2*(P-16)+1 -: 2];
		end else begin : g_zero
			assign pair = 2'b00;
		end

		always_comb begin
			rem_sh = {rem_i, pair};
			trial  = {2'b00, root_i, 2'b01};
			diff   = rem_sh - trial;
			take   = (rem_sh >= trial);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[gi] <= 1'b0;
			end else if (en) begin
				vld_s[gi] <= vld_i;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[gi]  <= take ? diff[RMW-1:0] : rem_sh[RMW-1:0];
				root_s[gi] <= {root_i[NR-2:0], take};
				d_s[gi]    <= d_i;
				tag_s[gi]  <= tag_i;
			end
		end
	end

	assign vld_out  = vld_s[NR-1];
	assign root_out = root_s[NR-1];
	assign tag_out  = tag_s[NR-1];

endmodule

FILE: src/qrs_div.sv
// Pipelined unsigned restoring divider, one quotient bit per stage.
module qrs_div import qrs_pkg::*; #(
	parameter int NW    = 34,
	parameter int DVW   = 17,
	parameter int TAG_W = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             vld_in,
	input  logic [NW-1:0]    num_in,
	input  logic [DVW-1:0]   den_in,
	input  logic [TAG_W-1:0] tag_in,
	output logic             vld_out,
	output logic [NW-1:0]    quo_out,
	output logic [TAG_W-1:0] tag_out
);

	logic             vld_s [NW];
	logic [DVW-1:0]   rem_s [NW];
	logic [NW-1:0]    quo_s [NW];
	logic [NW-1:0]    num_s [NW];
	logic [DVW-1:0]   den_s [NW];
	logic [TAG_W-1:0] tag_s [NW];

	for (genvar gi = 0; gi < NW; gi++) begin : g_stg
		logic             vld_i;
		logic [DVW-1:0]   rem_i;
		logic [NW-1:0]    quo_i;
		logic [NW-1:0]    num_i;
		logic [DVW-1:0]   den_i;
		logic [TAG_W-1:0] tag_i;
		logic [DVW:0]     rem_sh;
		logic [DVW:0]     diff;
		logic             take;

		if (gi == 0) begin : g_first
			assign vld_i = vld_in;
			assign rem_i = '0;
			assign quo_i = '0;
			assign num_i = num_in;
			assign den_i = den_in;
			assign tag_i = tag_in;
		end else begin : g_next
			assign vld_i = vld_s[gi-1];
			assign rem_i = rem_s[gi-1];
			assign quo_i = quo_s[gi-1];
			assign num_i = num_s[gi-1];
			assign den_i = den_s[gi-1];
			assign tag_i = tag_s[gi-1];
		end

		// bring down the next numerator bit and try the subtract
		always_comb begin
			rem_sh = {rem_i, num_i[NW-1]};
			diff   = rem_sh - {1'b0, den_i};
			take   = (rem_sh >= {1'b0, den_i});
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[gi] <= 1'b0;
			end else if (en) begin
				vld_s[gi] <= vld_i;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[gi] <= take ? diff[DVW-1:0] : rem_sh[DVW-1:0];
				quo_s[gi] <= {quo_i[NW-2:0], take};
				num_s[gi] <= {num_i[NW-2:0], 1'b0};
				den_s[gi] <= den_i;
				tag_s[gi] <= tag_i;
			end
		end
	end

	assign vld_out = vld_s[NW-1];
	assign quo_out = quo_s[NW-1];
	assign tag_out = tag_s[NW-1];

endmodule

FILE: src/quadratic_root_solver_top.sv
// Real roots of a*x^2+b*x+c from signed Q8.8 coefficients: class plus both
// roots in signed Q16.16, truncated toward zero and clipped to ROOT_WIDTH.
// Fully pipelined: one transaction in and one out per cycle when the output
// side is ready. The pipe is (CWE+17) square-root stages plus (CWE+18) divide
// stages plus 7 stages for capture, multiply, discriminant, numerator,
// magnitude, sign and clip, where CWE = min(COEF_WIDTH, 30). The whole pipe
// holds when a result waits and root_ready is low.
module quadratic_root_solver_top import qrs_pkg::*; #(
	parameter int COEF_WIDTH = 16,
	parameter int ROOT_WIDTH = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         coef_valid,
	output logic                         coef_ready,
	input  logic signed [COEF_WIDTH-1:0] coef_a,
	input  logic signed [COEF_WIDTH-1:0] coef_b,
	input  logic signed [COEF_WIDTH-1:0] coef_c,
	output logic                         root_valid,
	input  logic                         root_ready,
	output logic [1:0]                   root_class,
	output logic signed [ROOT_WIDTH-1:0] root_plus,
	output logic signed [ROOT_WIDTH-1:0] root_minus,
	output logic                         saturated
);

	localparam int CWE = (COEF_WIDTH > 30) ? 30 : COEF_WIDTH;
	localparam int DW  = 2*CWE + 2;
	localparam int NR  = CWE + 17;
	localparam int NW  = CWE + 18;
	localparam int DVW = CWE + 1;
	localparam int SQT = 2*CWE + 2;
	localparam int EW  = ((NW + 1 > ROOT_WIDTH) ? NW + 1 : ROOT_WIDTH) + 1;

	logic en;
	assign en         = !root_valid || root_ready;
	assign coef_ready = en;

	// stage 1: capture coefficients
	logic                  vld_s1;
	logic signed [CWE-1:0] a_s1, b_s1, c_s1;
	// stage 2: products
	logic                    vld_s2;
	logic signed [2*CWE-1:0] bb_s2, ac_s2;
	logic signed [CWE-1:0]   a_s2, b_s2;
	// stage 3: discriminant and class
	logic                  vld_s3;
	logic signed [DW-1:0]  d_s3;
	root_class_t           cls_s3;
	logic signed [CWE-1:0] a_s3, b_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s1 <= coef_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_s1  <= coef_a[CWE-1:0];
			b_s1  <= coef_b[CWE-1:0];
			c_s1  <= coef_c[CWE-1:0];
			bb_s2 <= b_s1 * b_s1;
			ac_s2 <= a_s1 * c_s1;
			a_s2  <= a_s1;
			b_s2  <= b_s1;
			d_s3  <= DW'(bb_s2) - (DW'(ac_s2) <<< 2);
			a_s3  <= a_s2;
			b_s3  <= b_s2;
		end
	end

	// class from a and the sign of the discriminant
	logic signed [DW-1:0] d_nxt;
	assign d_nxt = DW'(bb_s2) - (DW'(ac_s2) <<< 2);
	always_ff @(posedge clk) begin
		if (en) begin
			if (a_s2 == '0)
				cls_s3 <= CLS_AZERO;
			else if (d_nxt < 0)
				cls_s3 <= CLS_NONE;
			else if (d_nxt == '0)
				cls_s3 <= CLS_ONE;
			else
				cls_s3 <= CLS_TWO;
		end
	end

	// square root of the scaled discriminant
	logic           sq_vld;
	logic [NR-1:0]  sq_root;
	logic [SQT-1:0] sq_tag;

	qrs_sqrt #(.NR(NR), .TAG_W(SQT)) u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.vld_in   (vld_s3),
		.d_in     (d_s3[2*NR-33:0]),
		.tag_in   ({cls_s3, a_s3, b_s3}),
		.vld_out  (sq_vld),
		.root_out (sq_root),
		.tag_out  (sq_tag)
	);

	logic [1:0]            sq_cls;
	logic signed [CWE-1:0] sq_a, sq_b;
	assign {sq_cls, sq_a, sq_b} = sq_tag;

	// stage 4: numerators -65536*b +/- s and divisor |2a|
	logic                 vld_s4;
	logic signed [NW:0]   np_s4, nm_s4;
	logic [DVW-1:0]       den_s4;
	logic                 an_s4;
	logic [1:0]           cls_s4;
	logic signed [NW:0]   bsh;
	logic signed [NW:0]   sx;
	logic signed [DVW-1:0] a2;

	always_comb begin
		bsh = -((NW+1)'(sq_b) <<< FRAC_SHIFT);
		sx  = signed'({{(NW+1-NR){1'b0}}, sq_root});
		a2  = DVW'(sq_a) <<< 1;
	end

	// stage 5: magnitudes and quotient signs
	logic                 vld_s5;
	logic [NW-1:0]        mp_s5, mm_s5;
	logic [DVW-1:0]       den_s5;
	logic                 sp_s5, sm_s5;
	logic [1:0]           cls_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else if (en) begin
			vld_s4 <= sq_vld;
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			np_s4  <= bsh + sx;
			nm_s4  <= bsh - sx;
			den_s4 <= a2[DVW-1] ? DVW'(-a2) : DVW'(a2);
			an_s4  <= sq_a[CWE-1];
			cls_s4 <= sq_cls;
			mp_s5  <= np_s4[NW] ? NW'(-np_s4) : np_s4[NW-1:0];
			mm_s5  <= nm_s4[NW] ? NW'(-nm_s4) : nm_s4[NW-1:0];
			sp_s5  <= np_s4[NW] ^ an_s4;
			sm_s5  <= nm_s4[NW] ^ an_s4;
			den_s5 <= den_s4;
			cls_s5 <= cls_s4;
		end
	end

	// two dividers in lockstep
	logic          dv_vld;
	logic [NW-1:0] qp, qm;
	logic [2:0]    dp_tag;
	logic          dm_tag;

	qrs_div #(.NW(NW), .DVW(DVW), .TAG_W(3)) u_div_plus (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.vld_in  (vld_s5),
		.num_in  (mp_s5),
		.den_in  (den_s5),
		.tag_in  ({cls_s5, sp_s5}),
		.vld_out (dv_vld),
		.quo_out (qp),
		.tag_out (dp_tag)
	);

	qrs_div #(.NW(NW), .DVW(DVW), .TAG_W(1)) u_div_minus (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.vld_in  (vld_s5),
		.num_in  (mm_s5),
		.den_in  (den_s5),
		.tag_in  (sm_s5),
		.vld_out (),
		.quo_out (qm),
		.tag_out (dm_tag)
	);

	// stage 6: apply quotient signs
	logic                vld_s6;
	logic signed [EW-1:0] rp_s6, rm_s6;
	logic [1:0]          cls_s6;
	logic signed [EW-1:0] qp_x, qm_x;

	assign qp_x = signed'({{(EW-NW){1'b0}}, qp});
	assign qm_x = signed'({{(EW-NW){1'b0}}, qm});

	// stage 7: clip to the result range (output register)
	localparam logic signed [EW-1:0] HI_LIM =
		{{(EW-ROOT_WIDTH+1){1'b0}}, {(ROOT_WIDTH-1){1'b1}}};
	localparam logic signed [EW-1:0] LO_LIM = ~HI_LIM;

	logic                  hp, lp, hm, lm, zero_out;
	logic [ROOT_WIDTH-1:0] rp_c, rm_c;

	always_comb begin
		hp       = rp_s6 > HI_LIM;
		lp       = rp_s6 < LO_LIM;
		hm       = rm_s6 > HI_LIM;
		lm       = rm_s6 < LO_LIM;
		zero_out = (cls_s6 == CLS_NONE) || (cls_s6 == CLS_AZERO);
		rp_c     = hp ? HI_LIM[ROOT_WIDTH-1:0] : (lp ? LO_LIM[ROOT_WIDTH-1:0]
		                                             : rp_s6[ROOT_WIDTH-1:0]);
		rm_c     = hm ? HI_LIM[ROOT_WIDTH-1:0] : (lm ? LO_LIM[ROOT_WIDTH-1:0]
		                                             : rm_s6[ROOT_WIDTH-1:0]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s6     <= 1'b0;
			root_valid <= 1'b0;
		end else if (en) begin
			vld_s6     <= dv_vld;
			root_valid <= vld_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rp_s6      <= dp_tag[0] ? -qp_x : qp_x;
			rm_s6      <= dm_tag ? -qm_x : qm_x;
			cls_s6     <= dp_tag[2:1];
			root_class <= cls_s6;
			root_plus  <= zero_out ? '0 : rp_c;
			root_minus <= zero_out ? '0 : rm_c;
			saturated  <= !zero_out && (hp || lp || hm || lm);
		end
	end

endmodule

FILE: src/qrs_checker.sv
// Port-level checks for the quadratic root solver.
module qrs_checker import qrs_pkg::*; #(
	parameter int ROOT_WIDTH = 32
) (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  root_valid,
	input logic                  root_ready,
	input logic [1:0]            root_class,
	input logic [ROOT_WIDTH-1:0] root_plus,
	input logic [ROOT_WIDTH-1:0] root_minus,
	input logic                  saturated
);

	// a stalled result transaction holds its payload
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		root_valid && !root_ready |=> $stable(root_plus) && $stable(root_minus)
		&& $stable(root_class) && $stable(saturated))
		else $error("result changed while stalled");

	// no real root or a of zero: roots and saturation cleared
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		root_valid && (root_class == CLS_NONE || root_class == CLS_AZERO)
		|-> root_plus == '0 && root_minus == '0 && !saturated)
		else $error("nonzero roots without real solution");

	// a repeated root gives two equal values
	a_rep: assert property (@(posedge clk) disable iff (!arst_n)
		root_valid && root_class == CLS_ONE |-> root_plus == root_minus)
		else $error("repeated root values differ");

endmodule

bind quadratic_root_solver_top qrs_checker #(.ROOT_WIDTH(ROOT_WIDTH)) u_qrs_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.root_valid (root_valid),
	.root_ready (root_ready),
	.root_class (root_class),
	.root_plus  (root_plus),
	.root_minus (root_minus),
	.saturated  (saturated)
);
